// File: rtl/sfr_pkg.sv
// Shared types and constants for the split frame reassembler.
package sfr_pkg;

  localparam int FRAME_MAX_DEF    = 255;
  localparam int BUFFER_BYTES_DEF = 512;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // Job field widths, sized for the largest supported configuration
  localparam int LEN_W  = 13;
  localparam int ADDR_W = 12;
  localparam int CNT_W  = 8;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int SPLIT_BIT = 0;

  typedef enum logic [2:0] {
    KIND_REJECT   = 3'd0,
    KIND_HELD     = 3'd1,
    KIND_READY    = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_READ     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    JOB_RESULT = 2'd0,
    JOB_COPY   = 2'd1,
    JOB_READ   = 2'd2
  } job_op_t;

  // Work handed from the front end to the back end
  typedef struct packed {
    job_op_t               op;
    kind_t                 kind;
    logic [LEN_W-1:0]      length;
    logic [ADDR_W-1:0]     addr;
    logic [CNT_W-1:0]      count;
  } job_t;

endpackage

// File: rtl/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sfr_queue.sv
// Short job queue between the front end and the back end.
module sfr_queue #(
  parameter int DEPTH = sfr_pkg::QUEUE_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output sfr_pkg::job_t dout,
  output logic          empty
);
  import sfr_pkg::*;

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = slots[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/sfr_front.sv
// Front end: takes beats, stages frame bytes, judges frames and issues jobs.
module sfr_front #(
  parameter int FRAME_MAX    = sfr_pkg::FRAME_MAX_DEF,
  parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEF,
  localparam int SAW = (FRAME_MAX - 1 > 1) ? $clog2(FRAME_MAX - 1) : 1
) (
  input  logic           clk,
  input  logic           rst,
  // Input beats
  input  logic           push,
  output logic           full,
  input  logic           command,
  input  logic [7:0]     byte_value,
  input  logic           frame_end,
  input  logic [8:0]     read_index,
  // Staging store write port
  output logic           stg_we,
  output logic [SAW-1:0] stg_waddr,
  output logic [7:0]     stg_wdata,
  // Job queue
  output logic           q_push,
  output sfr_pkg::job_t  q_data,
  input  logic           q_full,
  input  logic           copy_done
);
  import sfr_pkg::*;

  localparam int LW  = $clog2(BUFFER_BYTES + 1);
  localparam int FCW = $clog2(FRAME_MAX + 2);
  localparam int SW  = ((LW > FCW) ? LW : FCW) + 1;

  logic [FCW-1:0] frame_count;
  logic [7:0]     frame_header;
  logic [LW-1:0]  stored_length;
  logic           held_valid;
  logic [3:0]     held_sequence;
  logic           copy_busy;

  logic [LW-1:0]  stored_length_next;
  logic           held_valid_next;
  logic [3:0]     held_sequence_next;

  logic           accept;
  logic           is_push;
  logic           bad_len;
  logic           split;
  logic [3:0]     seq;
  logic           seq_match;
  logic [SW-1:0]  sum;
  logic           idx_ok;

  // A push is held off while staged bytes still wait to be copied
  assign full    = q_full | copy_busy;
  assign accept  = push & ~full;
  assign is_push = (command == CMD_PUSH);

  // Staging store write
  assign stg_we    = accept & is_push & (frame_count != '0) &
                     (frame_count < FCW'(FRAME_MAX));
  assign stg_waddr = SAW'(frame_count - 1'b1);
  assign stg_wdata = byte_value;

  // Frame judgement; frame_count equals the payload size at the last beat
  assign bad_len   = (frame_count == '0) || (frame_count >= FCW'(FRAME_MAX));
  assign split     = frame_header[SPLIT_BIT];
  assign seq       = frame_header[7:4];
  assign seq_match = split & held_valid & (held_sequence == seq);
  assign sum       = SW'(stored_length) + SW'(frame_count);
  assign idx_ok    = 32'(read_index) < 32'(stored_length);

  assign q_push = accept & ((command == CMD_READ) | frame_end);

  // Job build and next held state
  always_comb begin
    stored_length_next = stored_length;
    held_valid_next    = held_valid;
    held_sequence_next = held_sequence;
    q_data.op          = JOB_RESULT;
    q_data.kind        = KIND_REJECT;
    q_data.addr        = '0;
    q_data.count       = CNT_W'(frame_count);
    if (command == CMD_READ) begin
      q_data.kind = KIND_READ;
      q_data.addr = ADDR_W'(read_index);
      if (idx_ok) begin
        q_data.op = JOB_READ;
      end
    end else if (bad_len) begin
      q_data.kind = KIND_REJECT;
    end else if (seq_match) begin
      if (sum > SW'(BUFFER_BYTES)) begin
        q_data.kind        = KIND_OVERFLOW;
        stored_length_next = '0;
        held_valid_next    = 1'b0;
      end else begin
        q_data.op          = JOB_COPY;
        q_data.kind        = KIND_READY;
        q_data.addr        = ADDR_W'(stored_length);
        stored_length_next = LW'(sum);
        held_valid_next    = 1'b0;
      end
    end else if (SW'(frame_count) > SW'(BUFFER_BYTES)) begin
      q_data.kind        = KIND_OVERFLOW;
      stored_length_next = '0;
      held_valid_next    = 1'b0;
    end else begin
      q_data.op          = JOB_COPY;
      stored_length_next = LW'(frame_count);
      if (split) begin
        q_data.kind        = KIND_HELD;
        held_valid_next    = 1'b1;
        held_sequence_next = seq;
      end else begin
        q_data.kind     = KIND_READY;
        held_valid_next = 1'b0;
      end
    end
    q_data.length = LEN_W'(stored_length_next);
  end

  // Header register
  always_ff @(posedge clk) begin
    if (accept && is_push && frame_count == '0) begin
      frame_header <= byte_value;
    end
  end

  // Frame and packet control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      stored_length <= '0;
      held_valid    <= 1'b0;
      held_sequence <= '0;
      copy_busy     <= 1'b0;
    end else begin
      if (copy_done) begin
        copy_busy <= 1'b0;
      end
      if (accept && is_push) begin
        if (!frame_end) begin
          if (frame_count != FCW'(FRAME_MAX + 1)) begin
            frame_count <= frame_count + 1'b1;
          end
        end else begin
          frame_count   <= '0;
          stored_length <= stored_length_next;
          held_valid    <= held_valid_next;
          held_sequence <= held_sequence_next;
          if (q_data.op == JOB_COPY) begin
            copy_busy <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: rtl/sfr_back.sv
// Back end: runs jobs, copies staged payload into the packet buffer, reads.
module sfr_back #(
  parameter int FRAME_MAX    = sfr_pkg::FRAME_MAX_DEF,
  parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEF,
  localparam int SAW = (FRAME_MAX - 1 > 1) ? $clog2(FRAME_MAX - 1) : 1
) (
  input  logic           clk,
  input  logic           rst,
  // Job queue
  input  logic           q_empty,
  output logic           q_pop,
  input  sfr_pkg::job_t  q_data,
  // Staging store read port
  output logic           stg_re,
  output logic [SAW-1:0] stg_raddr,
  input  logic [7:0]     stg_rdata,
  output logic           copy_done,
  // Result beats
  output logic           empty,
  input  logic           pop,
  output logic [2:0]     result_kind,
  output logic [9:0]     packet_length,
  output logic [7:0]     read_byte
);
  import sfr_pkg::*;

  localparam int BAW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  typedef enum logic [1:0] {
    B_IDLE,
    B_COPY,
    B_DRAIN,
    B_EMIT
  } state_t;

  state_t           state;
  job_t             job;
  logic [CNT_W-1:0] idx;
  logic             wr_pend;
  logic [BAW-1:0]   wr_addr;
  logic             out_valid;
  logic [2:0]       out_kind;
  logic [9:0]       out_len;
  logic [7:0]       out_byte;

  logic             out_free;
  logic             buf_re;
  logic [BAW-1:0]   buf_raddr;
  logic [7:0]       buf_rdata;

  assign out_free  = ~out_valid | pop;
  assign q_pop     = (state == B_IDLE) & ~q_empty;
  assign stg_re    = (state == B_COPY);
  assign stg_raddr = SAW'(idx);
  assign buf_re    = q_pop & (q_data.op == JOB_READ);
  assign buf_raddr = BAW'(q_data.addr);
  assign copy_done = (state == B_EMIT) & out_free & (job.op == JOB_COPY);

  assign empty         = ~out_valid;
  assign result_kind   = out_kind;
  assign packet_length = out_len;
  assign read_byte     = out_byte;

  // Packet buffer; each write lands in the cycle after its staging read
  sfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_buffer (
    .clk   (clk),
    .we    (wr_pend),
    .waddr (wr_addr),
    .wdata (stg_rdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // Job sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wr_pend <= (state == B_COPY);
      // In B_EMIT a pop always frees the register, which is refilled below
      if (pop && out_valid && state != B_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job   <= q_data;
            idx   <= '0;
            state <= (q_data.op == JOB_COPY) ? B_COPY : B_EMIT;
          end
        end
        B_COPY: begin
          wr_addr <= BAW'(job.addr + ADDR_W'(idx));
          idx     <= idx + 1'b1;
          if (idx == job.count - 1'b1) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= job.kind;
            out_len   <= job.length[9:0];
            out_byte  <= (job.op == JOB_READ) ? buf_rdata : 8'd0;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/split_frame_reassembler.sv
// Top level: rebuilds packets from one or two frames and serves byte reads.
// A frame end that loads the buffer copies one byte a cycle over the staging
// store read port, so its result and the release of full come only after the
// copy; other results leave through the job queue and the result register,
// reads included.
// Synchronous reset clears control state; the stores have no clearing pass.
module split_frame_reassembler #(
  parameter int FRAME_MAX    = sfr_pkg::FRAME_MAX_DEF,
  parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEF,
  parameter int QUEUE_DEPTH  = sfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       command,
  input  logic [7:0] byte_value,
  input  logic       frame_end,
  input  logic [8:0] read_index,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] result_kind,
  output logic [9:0] packet_length,
  output logic [7:0] read_byte
);
  import sfr_pkg::*;

  localparam int SAW = (FRAME_MAX - 1 > 1) ? $clog2(FRAME_MAX - 1) : 1;

  logic           stg_we;
  logic [SAW-1:0] stg_waddr;
  logic [7:0]     stg_wdata;
  logic           stg_re;
  logic [SAW-1:0] stg_raddr;
  logic [7:0]     stg_rdata;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  job_t           q_in;
  job_t           q_out;
  logic           copy_done;

  sfr_front #(
    .FRAME_MAX    (FRAME_MAX),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .byte_value (byte_value),
    .frame_end  (frame_end),
    .read_index (read_index),
    .stg_we     (stg_we),
    .stg_waddr  (stg_waddr),
    .stg_wdata  (stg_wdata),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full),
    .copy_done  (copy_done)
  );

  // Payload bytes of the frame in progress
  sfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_MAX - 1)
  ) u_staging (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (stg_wdata),
    .re    (stg_re),
    .raddr (stg_raddr),
    .rdata (stg_rdata)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  sfr_back #(
    .FRAME_MAX    (FRAME_MAX),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_out),
    .stg_re        (stg_re),
    .stg_raddr     (stg_raddr),
    .stg_rdata     (stg_rdata),
    .copy_done     (copy_done),
    .empty         (empty),
    .pop           (pop),
    .result_kind   (result_kind),
    .packet_length (packet_length),
    .read_byte     (read_byte)
  );

endmodule
